@@ design/arpc_pkg.sv @@
// Shared constants, codes and types of the ARP address cache.
package arpc_pkg;

	localparam int unsigned ENTRIES = 8;
	localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned IP_W    = 32;
	localparam int unsigned MAC_W   = 48;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_LEARN  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] widx;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} tbl_cmd_t;

	typedef struct packed {
		logic             valid;
		logic             match;
		logic [MAC_W-1:0] mac;
	} tbl_stat_t;

endpackage

@@ design/arpc_table.sv @@
// Entry storage, valid flags and the shared address comparator.
module arpc_table import arpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	input  tbl_cmd_t         cmd,
	output tbl_stat_t        stat
);

	logic [IP_W-1:0]    ip_mem  [ENTRIES];
	logic [MAC_W-1:0]   mac_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			ip_mem[cmd.widx]  <= cmd.ip;
			mac_mem[cmd.widx] <= cmd.mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.we) begin
			valid_q[cmd.widx] <= 1'b1;
		end
	end

	always_comb begin
		stat.valid = valid_q[rd_idx];
		stat.match = valid_q[rd_idx] && (ip_mem[rd_idx] == cmd.ip);
		stat.mac   = mac_mem[rd_idx];
	end

endmodule

@@ design/arp_address_cache.sv @@
// Top level of the ARP address cache: scan sequencer, replacement pointer, result register.
//
//  channel | dir | tdata                          | tuser
//  s_      | in  | ip_addr[31:0], mac_addr[79:32] | func[0] (0 lookup, 1 learn)
//  m_      | out | mac_out[47:0]                  | hit[0]
//
// An item takes its accept state, one scan step per entry (ENTRIES at most, fewer on
// an early match), the write state and the result state; the scan is serial, since the
// single comparator walks the table. Reset clears the valid flags and the pointer at
// once. A stalled result beat holds the sequencer in its last state.
module arp_address_cache import arpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // ip_addr[31:0], mac_addr[79:32]
	input  logic [0:0]  s_tuser,   // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // mac_out[47:0]
	output logic [0:0]  m_tuser    // hit[0]
);

	state_t           state_q, state_d;
	logic             func_q;
	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic [IDX_W-1:0] idx_q;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [MAC_W-1:0] hit_mac_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] ptr_q;
	logic             idx_last;
	logic             out_free;
	logic             load_out;
	logic             use_ptr;
	tbl_cmd_t         cmd;
	tbl_stat_t        stat;

	arpc_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx_q),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign idx_last = (idx_q == IDX_W'(ENTRIES - 1));
	assign out_free = !m_tvalid || m_tready;
	assign use_ptr  = !found_q && !free_found_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_SCAN;
			ST_SCAN:  if (stat.match || idx_last) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		cmd.we   = 1'b0;
		cmd.ip   = ip_q;
		cmd.mac  = mac_q;
		cmd.widx = found_idx_q;
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_SCAN:  ;
			ST_WRITE: begin
				cmd.we = (func_q == FUNC_LEARN);
				priority if (found_q) cmd.widx = found_idx_q;
				else if (free_found_q) cmd.widx = free_idx_q;
				else cmd.widx = ptr_q;
			end
			ST_DONE:  load_out = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.we && use_ptr) begin
				ptr_q <= (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q       <= s_tuser[0];
				ip_q         <= s_tdata[IP_W-1:0];
				mac_q        <= s_tdata[IP_W+MAC_W-1:IP_W];
				idx_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			ST_SCAN: begin
				if (stat.match) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_q;
					hit_mac_q   <= stat.mac;
				end else begin
					if (!stat.valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					if (!idx_last) idx_q <= idx_q + 1'b1;
				end
			end
			ST_WRITE: ;
			ST_DONE:  ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tuser[0] <= found_q;
			m_tdata    <= (found_q && func_q == FUNC_LOOKUP) ? hit_mac_q : '0;
		end
	end

	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && !(func_q == FUNC_LEARN && use_ptr)) |=> $stable(ptr_q))
		else $error("replacement pointer moved without an overwrite");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result beat not presented after scan");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("miss beat carries a non-zero MAC");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && idx_last) |=> (state_q == ST_WRITE))
		else $error("scan ran past the last entry");

endmodule

@@ tb/sv/arp_address_cache_tb.sv @@
// Self-checking stream testbench of the ARP address cache with a shadow table predictor.
module arp_address_cache_tb import arpc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 400;
	localparam int POOL_SIZE   = ENTRIES + 4;

	typedef struct packed {
		logic             hit;
		logic [MAC_W-1:0] mac;
	} arp_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;   // ip_addr[31:0], mac_addr[79:32]
	logic [0:0]  s_tuser = '0;   // func[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // mac_out[47:0]
	logic [0:0]  m_tuser;        // hit[0]

	logic [IP_W-1:0]  shadow_ip [ENTRIES];
	logic [MAC_W-1:0] shadow_mac [ENTRIES];
	logic             shadow_valid [ENTRIES];
	logic [IDX_W-1:0] shadow_ptr;

	arp_reply_t       pending_replies [$];
	logic [IP_W-1:0]  addr_pool [POOL_SIZE];

	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	logic rx_hold = 1'b0;
	event hold_req;
	int   err_count = 0;
	int   n_lookup = 0;
	int   n_learn = 0;
	int   n_hit = 0;
	int   n_replace = 0;

	arp_address_cache dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic arp_reply_t cache_predict(logic func, logic [IP_W-1:0] ip,
		logic [MAC_W-1:0] mac);
		int         idx;
		int         slot;
		arp_reply_t r;
		idx = -1;
		slot = -1;
		for (int k = 0; k < ENTRIES; k++) begin
			if (idx < 0 && shadow_valid[k] && shadow_ip[k] == ip) begin
				idx = k;
			end
		end
		r.hit = (idx >= 0);
		r.mac = '0;
		if (func == FUNC_LOOKUP) begin
			if (idx >= 0) begin
				r.mac = shadow_mac[idx];
			end
		end else if (idx >= 0) begin
			shadow_mac[idx] = mac;
		end else begin
			for (int k = 0; k < ENTRIES; k++) begin
				if (slot < 0 && !shadow_valid[k]) begin
					slot = k;
				end
			end
			if (slot < 0) begin
				slot = shadow_ptr;
				shadow_ptr = (shadow_ptr == IDX_W'(ENTRIES - 1)) ? '0 : shadow_ptr + 1'b1;
				n_replace++;
			end
			shadow_ip[slot] = ip;
			shadow_mac[slot] = mac;
			shadow_valid[slot] = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		arp_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected result beat: hit %0b mac_out %h", m_tuser[0], m_tdata);
				err_count++;
			end else begin
				want = pending_replies.pop_front();
				if (m_tuser[0] !== want.hit) begin
					$error("hit: expected %0b, actual %0b", want.hit, m_tuser[0]);
					err_count++;
				end
				if (m_tdata !== want.mac) begin
					$error("mac_out: expected %h, actual %h", want.mac, m_tdata);
					err_count++;
				end
			end
		end
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		forever begin
			@(hold_req);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	task automatic send_item(logic func, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
		arp_reply_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {mac, ip};
		s_tuser <= func;
		do @(posedge clk); while (!s_tready);
		r = cache_predict(func, ip, mac);
		pending_replies.push_back(r);
		if (func == FUNC_LOOKUP) begin
			n_lookup++;
		end else begin
			n_learn++;
		end
		if (r.hit) begin
			n_hit++;
		end
	endtask

	function automatic logic [MAC_W-1:0] rand_mac();
		return MAC_W'({$urandom, $urandom});
	endfunction

	task automatic send_random();
		logic            func;
		logic [IP_W-1:0] ip;
		func = $urandom_range(1) ? FUNC_LEARN : FUNC_LOOKUP;
		ip = ($urandom_range(9) == 0) ? $urandom : addr_pool[$urandom_range(POOL_SIZE - 1)];
		send_item(func, ip, rand_mac());
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (2 * (ENTRIES + 3)) @(posedge clk);
	endtask

	task automatic test_lookup_miss();
		send_item(FUNC_LOOKUP, '0, rand_mac());
		send_item(FUNC_LOOKUP, '1, rand_mac());
	endtask

	task automatic test_learn_extremes();
		send_item(FUNC_LEARN, '0, '0);
		send_item(FUNC_LEARN, '1, '1);
		send_item(FUNC_LOOKUP, '0, '1);
		send_item(FUNC_LOOKUP, '1, '0);
		send_item(FUNC_LEARN, '0, 48'ha5a5_5a5a_a5a5);
		send_item(FUNC_LOOKUP, '0, '0);
	endtask

	task automatic test_fill_and_evict();
		for (int k = 0; k < ENTRIES - 2; k++) begin
			send_item(FUNC_LEARN, 32'hc0a8_0100 + k, rand_mac());
		end
		for (int k = 0; k <= ENTRIES; k++) begin
			send_item(FUNC_LEARN, 32'h0a00_0000 + k, rand_mac());
		end
		send_item(FUNC_LOOKUP, 32'hc0a8_0100, '0);
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				foreach (addr_pool[k]) addr_pool[k] = $urandom;
			end
			send_random();
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		-> hold_req;
		repeat (40) send_random();
		wait_drain();
	endtask

	initial begin
		for (int k = 0; k < ENTRIES; k++) begin
			shadow_ip[k] = '0;
			shadow_mac[k] = '0;
			shadow_valid[k] = 1'b0;
		end
		shadow_ptr = '0;
		foreach (addr_pool[k]) addr_pool[k] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 19;
		rx_idle_pct = 62;
		test_lookup_miss();
		test_learn_extremes();
		test_fill_and_evict();
		wait_drain();
		test_random(390);

		tx_idle_pct = 62;
		rx_idle_pct = 19;
		test_random(390);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_backpressure();
		test_random(400);

		$display("Covered %0d lookups and %0d learns: %0d hits, %0d round-robin overwrites.",
			n_lookup, n_learn, n_hit, n_replace);
		$display("Receiver held off for %0d cycles while the sender kept offering beats.",
			HOLD_CYCLES);
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
